/* hw/rtl/q2e_pkg.sv */
// Shared types, widths and constants for the quaternion to Euler angle core.
// Holds the arctangent table of the CORDIC cells. No dependencies.
package q2e_pkg;

	// default depth of the arctangent cell chain
	localparam int CORDIC_STAGES_DEF = 16;
	// entries in the arctangent table
	localparam int TAB_LEN = 24;

	// width of the sine and cosine terms, scaled by 2^30
	localparam int SW = 34;
	// width of the CORDIC vector coordinates
	localparam int CW = 38;
	// width of the angle accumulator, Q6.30
	localparam int ZW = 36;
	// width of the square root remainder and partial root
	localparam int RW = 62;
	// width of the final root
	localparam int ROOT_W = 31;
	// width of the pitch sine magnitude fed to the square root
	localparam int MAG_W = 30;
	// one root digit per cell
	localparam int SQRT_STAGES = 31;

	localparam logic signed [SW-1:0] ONE_Q30 = SW'(64'sd1073741824);
	localparam logic signed [ZW-1:0] PI_Q30 = ZW'(64'sd3373259426);
	localparam logic signed [15:0] PI_Q13 = 16'sd25736;
	localparam logic signed [15:0] HALF_PI_Q13 = 16'sd12868;

	// vector and angle held by one CORDIC cell
	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [ZW-1:0] z;
		logic done;
	} cordic_t;

	// terms carried alongside the square root chain
	typedef struct packed {
		logic signed [SW-1:0] sinr;
		logic signed [SW-1:0] cosr;
		logic signed [SW-1:0] siny;
		logic signed [SW-1:0] cosy;
		logic signed [SW-1:0] sinp;
		logic clamp;
	} side_t;

	// atan(2^-i) in Q2.30, truncated
	function automatic logic [31:0] atan_q30(input int i);
		logic [31:0] v;
		case (i)
			0: v = 32'h3243F6A8;
			1: v = 32'h1DAC6705;
			2: v = 32'h0FADBAFC;
			3: v = 32'h07F56EA6;
			4: v = 32'h03FEAB76;
			5: v = 32'h01FFD55B;
			6: v = 32'h00FFFAAA;
			7: v = 32'h007FFF55;
			8: v = 32'h003FFFEA;
			9: v = 32'h001FFFFD;
			10: v = 32'h000FFFFF;
			11: v = 32'h0007FFFF;
			12: v = 32'h0003FFFF;
			13: v = 32'h0001FFFF;
			14: v = 32'h0000FFFF;
			15: v = 32'h00007FFF;
			16: v = 32'h00003FFF;
			17: v = 32'h00001FFF;
			18: v = 32'h00000FFF;
			19: v = 32'h000007FF;
			20: v = 32'h000003FF;
			21: v = 32'h000001FF;
			22: v = 32'h000000FF;
			23: v = 32'h0000007F;
			default: v = 32'h0;
		endcase
		return v;
	endfunction

endpackage

/* hw/rtl/q2e_sqrt_cell.sv */
// One digit cell of the pipelined integer square root.
// Depends on q2e_pkg for widths and the side term struct.
module q2e_sqrt_cell #(
	parameter int K = 0
) (
	input  logic clk,
	input  logic en,
	input  logic [q2e_pkg::RW-1:0] rem_i,
	input  logic [q2e_pkg::RW-1:0] root_i,
	input  q2e_pkg::side_t side_i,
	output logic [q2e_pkg::RW-1:0] rem_s1,
	output logic [q2e_pkg::RW-1:0] root_s1,
	output q2e_pkg::side_t side_s1
);

	localparam logic [q2e_pkg::RW-1:0] TAP = q2e_pkg::RW'(1) << (2 * K);

	logic [q2e_pkg::RW-1:0] trial;
	logic fits;

	// try the next root digit against the remainder
	assign trial = root_i + TAP;
	assign fits = (rem_i >= trial);

	// advance remainder, root and side terms
	always_ff @(posedge clk) begin
		if (en) begin
			rem_s1 <= fits ? (rem_i - trial) : rem_i;
			root_s1 <= fits ? ((root_i >> 1) + TAP) : (root_i >> 1);
			side_s1 <= side_i;
		end
	end

endmodule

/* hw/rtl/q2e_cordic_cell.sv */
// One vectoring iteration of the arctangent CORDIC chain.
// Depends on q2e_pkg for the cell struct and the arctangent table.
module q2e_cordic_cell #(
	parameter int STAGE = 0
) (
	input  logic clk,
	input  logic en,
	input  q2e_pkg::cordic_t vec_i,
	output q2e_pkg::cordic_t vec_s1
);

	localparam logic signed [q2e_pkg::ZW-1:0] ANG =
		q2e_pkg::ZW'(signed'({1'b0, q2e_pkg::atan_q30(STAGE)}));

	logic signed [q2e_pkg::CW-1:0] dx;
	logic signed [q2e_pkg::CW-1:0] dy;
	q2e_pkg::cordic_t nxt;

	// rotate toward the x axis by the sign of y
	always_comb begin
		dx = vec_i.y >>> STAGE;
		dy = vec_i.x >>> STAGE;
		nxt = vec_i;
		if (!vec_i.done) begin
			if (!vec_i.y[q2e_pkg::CW-1]) begin
				nxt.x = vec_i.x + dx;
				nxt.y = vec_i.y - dy;
				nxt.z = vec_i.z + ANG;
			end else begin
				nxt.x = vec_i.x - dx;
				nxt.y = vec_i.y + dy;
				nxt.z = vec_i.z - ANG;
			end
		end
	end

	// hand the vector to the next cell
	always_ff @(posedge clk) begin
		if (en) begin
			vec_s1 <= nxt;
		end
	end

endmodule

/* hw/rtl/quaternion_to_euler_core.sv */
// Top level of the quaternion to ZYX Euler angle core.
// Depends on q2e_pkg, q2e_sqrt_cell and q2e_cordic_cell.
//
// Takes one quaternion word (w, x, y, z, signed Q1.15) per cycle unless stalled and
// returns roll, pitch and yaw in radians (roll and yaw signed Q3.13, pitch signed
// Q2.13), with pitch_clamped set when the pitch sine term reaches magnitude one.
// Throughput is one word per clock when not stalled. A word passes the product, term
// and radicand registers, 31 square root digit cells for the pitch cosine, a quadrant
// fix-up register, one CORDIC cell per stage for each of the three angles, and the
// output register. The whole pipeline stalls only while a finished word waits at the
// output and the downstream side is not ready.
module quaternion_to_euler_core #(
	parameter int CORDIC_STAGES = q2e_pkg::CORDIC_STAGES_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic signed [15:0] quat_w,
	input  logic signed [15:0] quat_x,
	input  logic signed [15:0] quat_y,
	input  logic signed [15:0] quat_z,
	output logic out_valid,
	input  logic out_ready,
	output logic signed [15:0] roll_angle,
	output logic signed [14:0] pitch_angle,
	output logic signed [15:0] yaw_angle,
	output logic pitch_clamped
);

	localparam int SW = q2e_pkg::SW;
	localparam int CW = q2e_pkg::CW;
	localparam int ZW = q2e_pkg::ZW;
	localparam int RW = q2e_pkg::RW;
	localparam int NSQ = q2e_pkg::SQRT_STAGES;

	logic en;

	// front end registers
	logic vld_s1, vld_s2;
	logic signed [31:0] prod_s1 [9];
	q2e_pkg::side_t side_s2;
	logic [q2e_pkg::MAG_W-1:0] mag_s2;
	logic [RW-1:0] rad_s3;
	q2e_pkg::side_t side_s3;

	// square root chain
	logic vld_sq [NSQ+1];
	logic [RW-1:0] rem_c [NSQ+1];
	logic [RW-1:0] root_c [NSQ+1];
	q2e_pkg::side_t side_c [NSQ+1];

	// CORDIC chain: lane 0 roll, lane 1 pitch, lane 2 yaw
	logic vld_cd [CORDIC_STAGES+1];
	logic clamp_cd [CORDIC_STAGES+1];
	logic pos_cd [CORDIC_STAGES+1];
	q2e_pkg::cordic_t lane_c [3][CORDIC_STAGES+1];

	logic signed [SW-1:0] sinr, cosr, sinp, siny, cosy;
	logic clamp;
	logic [SW-1:0] sinp_abs;
	logic signed [SW-1:0] root_sw;

	function automatic q2e_pkg::cordic_t prep(input logic signed [SW-1:0] s,
		input logic signed [SW-1:0] c);
		q2e_pkg::cordic_t r;
		r.x = CW'(c);
		r.y = CW'(s);
		r.z = '0;
		r.done = 1'b0;
		if (s == '0) begin
			r.done = 1'b1;
			r.z = (c < 0) ? q2e_pkg::PI_Q30 : '0;
		end else if (c < 0) begin
			r.z = (s > 0) ? q2e_pkg::PI_Q30 : -q2e_pkg::PI_Q30;
			r.x = -CW'(c);
			r.y = -CW'(s);
		end
		return r;
	endfunction

	function automatic logic signed [15:0] to_q13(input logic signed [ZW-1:0] a,
		input logic signed [15:0] lim);
		logic signed [ZW-1:0] t;
		logic signed [ZW-18:0] r;
		logic signed [15:0] o;
		t = a + ZW'(65536);
		r = (ZW-17)'(t >>> 17);
		if (r > (ZW-17)'(lim))
			o = lim;
		else if (r < -(ZW-17)'(lim))
			o = -lim;
		else
			o = r[15:0];
		return o;
	endfunction

	// stall the whole pipeline only while the output word is held
	assign en = !out_valid || out_ready;
	assign in_ready = en;

	// form the sine and cosine terms from the products
	always_comb begin
		sinr = (SW'(prod_s1[0]) + SW'(prod_s1[1])) <<< 1;
		cosr = q2e_pkg::ONE_Q30 - ((SW'(prod_s1[2]) + SW'(prod_s1[3])) <<< 1);
		sinp = (SW'(prod_s1[4]) - SW'(prod_s1[5])) <<< 1;
		siny = (SW'(prod_s1[6]) + SW'(prod_s1[7])) <<< 1;
		cosy = q2e_pkg::ONE_Q30 - ((SW'(prod_s1[3]) + SW'(prod_s1[8])) <<< 1);
		clamp = (sinp >= q2e_pkg::ONE_Q30) || (sinp <= -q2e_pkg::ONE_Q30);
		sinp_abs = sinp[SW-1] ? SW'(-sinp) : SW'(sinp);
	end

	// register products, terms and the square root radicand
	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1[0] <= quat_w * quat_x;
			prod_s1[1] <= quat_y * quat_z;
			prod_s1[2] <= quat_x * quat_x;
			prod_s1[3] <= quat_y * quat_y;
			prod_s1[4] <= quat_w * quat_y;
			prod_s1[5] <= quat_z * quat_x;
			prod_s1[6] <= quat_w * quat_z;
			prod_s1[7] <= quat_x * quat_y;
			prod_s1[8] <= quat_z * quat_z;
			side_s2 <= '{sinr: sinr, cosr: cosr, siny: siny, cosy: cosy,
				sinp: sinp, clamp: clamp};
			mag_s2 <= clamp ? '0 : sinp_abs[q2e_pkg::MAG_W-1:0];
			rad_s3 <= (RW'(1) << 60) - (RW'(mag_s2) * RW'(mag_s2));
			side_s3 <= side_s2;
		end
	end

	// track valid words through the pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			for (int i = 0; i <= NSQ; i++) vld_sq[i] <= 1'b0;
			for (int i = 0; i <= CORDIC_STAGES; i++) vld_cd[i] <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_sq[0] <= vld_s2;
			for (int i = 1; i <= NSQ; i++) vld_sq[i] <= vld_sq[i-1];
			vld_cd[0] <= vld_sq[NSQ];
			for (int i = 1; i <= CORDIC_STAGES; i++) vld_cd[i] <= vld_cd[i-1];
			out_valid <= vld_cd[CORDIC_STAGES];
		end
	end

	assign rem_c[0] = rad_s3;
	assign root_c[0] = '0;
	assign side_c[0] = side_s3;

	// one root digit per cell, most significant first
	for (genvar g = 0; g < NSQ; g++) begin : g_sqrt
		q2e_sqrt_cell #(.K(NSQ - 1 - g)) u_cell (
			.clk(clk),
			.en(en),
			.rem_i(rem_c[g]),
			.root_i(root_c[g]),
			.side_i(side_c[g]),
			.rem_s1(rem_c[g+1]),
			.root_s1(root_c[g+1]),
			.side_s1(side_c[g+1])
		);
	end

	assign root_sw = SW'(signed'({1'b0, root_c[NSQ][q2e_pkg::ROOT_W-1:0]}));

	// fold each vector into the right half plane
	always_ff @(posedge clk) begin
		if (en) begin
			lane_c[0][0] <= prep(side_c[NSQ].sinr, side_c[NSQ].cosr);
			lane_c[1][0] <= prep(side_c[NSQ].sinp, root_sw);
			lane_c[2][0] <= prep(side_c[NSQ].siny, side_c[NSQ].cosy);
			clamp_cd[0] <= side_c[NSQ].clamp;
			pos_cd[0] <= (side_c[NSQ].sinp > 0);
			for (int i = 1; i <= CORDIC_STAGES; i++) begin
				clamp_cd[i] <= clamp_cd[i-1];
				pos_cd[i] <= pos_cd[i-1];
			end
		end
	end

	// CORDIC cells, one per stage in each lane
	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
		for (genvar j = 0; j < 3; j++) begin : g_lane
			q2e_cordic_cell #(.STAGE(i)) u_cell (
				.clk(clk),
				.en(en),
				.vec_i(lane_c[j][i]),
				.vec_s1(lane_c[j][i+1])
			);
		end
	end

	// round to Q3.13 and saturate into the output register
	always_ff @(posedge clk) begin
		logic signed [15:0] pv;
		if (en) begin
			pv = to_q13(lane_c[1][CORDIC_STAGES].z, q2e_pkg::HALF_PI_Q13);
			roll_angle <= to_q13(lane_c[0][CORDIC_STAGES].z, q2e_pkg::PI_Q13);
			yaw_angle <= to_q13(lane_c[2][CORDIC_STAGES].z, q2e_pkg::PI_Q13);
			if (clamp_cd[CORDIC_STAGES])
				pitch_angle <= pos_cd[CORDIC_STAGES] ? q2e_pkg::HALF_PI_Q13[14:0]
					: 15'(-q2e_pkg::HALF_PI_Q13);
			else
				pitch_angle <= pv[14:0];
			pitch_clamped <= clamp_cd[CORDIC_STAGES];
		end
	end

	// a saturated pitch sits exactly at plus or minus pi/2
	a_clamp_half_pi: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && pitch_clamped |->
		(pitch_angle == q2e_pkg::HALF_PI_Q13[14:0]) ||
		(pitch_angle == 15'(-q2e_pkg::HALF_PI_Q13)))
		else $error("clamped pitch is not +-pi/2");

	// roll and yaw never leave the range of +-pi
	a_roll_yaw_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (roll_angle <= q2e_pkg::PI_Q13) && (roll_angle >= -q2e_pkg::PI_Q13)
		&& (yaw_angle <= q2e_pkg::PI_Q13) && (yaw_angle >= -q2e_pkg::PI_Q13))
		else $error("roll or yaw out of range");

	// an output word that is not taken moves nothing in the pipeline
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(vld_cd[CORDIC_STAGES]) && $stable(vld_s1))
		else $error("pipeline moved during stall");

endmodule

/* tb/tb_quaternion_to_euler_core.sv */
// Self-checking testbench for quaternion_to_euler_core: drives quaternion words,
// predicts roll, pitch and yaw with an integer CORDIC model and checks each result.
// Depends on q2e_pkg and the core RTL.
`timescale 1ns / 1ps

module tb_quaternion_to_euler_core;

	localparam int STAGES = q2e_pkg::CORDIC_STAGES_DEF;
	localparam int LATENCY = 36 + STAGES;
	localparam int N_RANDOM = 1700;
	localparam longint CYCLE_LIMIT = 400000;
	localparam longint PI_Q30_L = 64'sd3373259426;
	localparam longint ONE_Q30_L = 64'sd1073741824;
	localparam longint PI_Q13_L = 64'sd25736;
	localparam longint HALF_PI_Q13_L = 64'sd12868;

	typedef struct packed {
		logic signed [15:0] w;
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic signed [15:0] z;
	} quat_t;

	typedef struct packed {
		logic signed [15:0] roll;
		logic signed [14:0] pitch;
		logic signed [15:0] yaw;
		logic clamped;
	} euler_t;

	// directed row: a word, and an expected result where it is plain to see
	typedef struct {
		quat_t q;
		bit has_exp;
		euler_t e;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [15:0] quat_w = '0, quat_x = '0, quat_y = '0, quat_z = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [15:0] roll_angle;
	logic signed [14:0] pitch_angle;
	logic signed [15:0] yaw_angle;
	logic pitch_clamped;

	euler_t angles_due[$];
	int errors = 0;
	longint cycles = 0;
	bit stim_done = 1'b0;
	bit hold_off = 1'b0;

	quaternion_to_euler_core #(.CORDIC_STAGES(STAGES)) u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.quat_w(quat_w), .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z),
		.out_valid(out_valid), .out_ready(out_ready),
		.roll_angle(roll_angle), .pitch_angle(pitch_angle),
		.yaw_angle(yaw_angle), .pitch_clamped(pitch_clamped)
	);

	always #6 clk = ~clk;

	// floor shift right
	function automatic longint floor_shr(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint angle_of(longint yv, longint xv);
		longint ang, dx, dy;
		longint tab[24] = '{
			64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
			64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
			64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
			64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
			64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F};
		ang = 0;
		if (yv == 0)
			return (xv < 0) ? PI_Q30_L : 0;
		// turn by pi into the right half plane
		if (xv < 0) begin
			ang = (yv > 0) ? PI_Q30_L : -PI_Q30_L;
			xv = -xv;
			yv = -yv;
		end
		for (int i = 0; i < STAGES && i < 24; i++) begin
			dx = floor_shr(yv, i);
			dy = floor_shr(xv, i);
			if (yv >= 0) begin
				xv += dx; yv -= dy; ang += tab[i];
			end else begin
				xv -= dx; yv += dy; ang -= tab[i];
			end
		end
		return ang;
	endfunction

	function automatic longint round_q13(longint a, longint lim);
		longint r;
		r = floor_shr(a + (64'sd1 <<< 16), 17);
		if (r > lim) r = lim;
		if (r < -lim) r = -lim;
		return r;
	endfunction

	function automatic longint unsigned root_floor(longint unsigned n);
		longint unsigned res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > n) b >>= 2;
		while (b != 0) begin
			if (n >= res + b) begin
				n -= res + b;
				res = (res >> 1) + b;
			end else
				res >>= 1;
			b >>= 2;
		end
		return res;
	endfunction

	function automatic euler_t euler_of(quat_t q);
		longint w, x, y, z, sinr, cosr, sinp, siny, cosy, c;
		longint unsigned sq;
		euler_t e;
		w = q.w; x = q.x; y = q.y; z = q.z;
		sinr = 2 * (w * x + y * z);
		cosr = ONE_Q30_L - 2 * (x * x + y * y);
		sinp = 2 * (w * y - z * x);
		siny = 2 * (w * z + x * y);
		cosy = ONE_Q30_L - 2 * (y * y + z * z);
		e.roll = 16'(round_q13(angle_of(sinr, cosr), PI_Q13_L));
		e.yaw = 16'(round_q13(angle_of(siny, cosy), PI_Q13_L));
		// saturate pitch at magnitude one
		if (sinp >= ONE_Q30_L || sinp <= -ONE_Q30_L) begin
			e.pitch = 15'((sinp > 0) ? HALF_PI_Q13_L : -HALF_PI_Q13_L);
			e.clamped = 1'b1;
		end else begin
			sq = sinp * sinp;
			c = root_floor((64'd1 << 60) - sq);
			e.pitch = 15'(round_q13(angle_of(sinp, c), HALF_PI_Q13_L));
			e.clamped = 1'b0;
		end
		return e;
	endfunction

	// present one word, hold until accepted; drop valid only while idling
	task automatic send_word(quat_t q, bit has_exp, euler_t e);
		while ($urandom_range(99) < 10 && cycles > 500) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		{quat_w, quat_x, quat_y, quat_z} <= q;
		angles_due.push_back(has_exp ? e : euler_of(q));
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		@(negedge clk);
	endtask

	function automatic quat_t rand_quat();
		quat_t q;
		int mode;
		real n;
		mode = $urandom_range(9);
		q = {$urandom, $urandom};
		// mostly near-unit quaternions, some with small w and x, the rest raw noise
		if (mode < 6) begin
			n = $sqrt(real'(q.w) ** 2 + real'(q.x) ** 2 + real'(q.y) ** 2
				+ real'(q.z) ** 2);
			if (n > 0) begin
				q.w = 16'($rtoi(q.w * 32700.0 / n));
				q.x = 16'($rtoi(q.x * 32700.0 / n));
				q.y = 16'($rtoi(q.y * 32700.0 / n));
				q.z = 16'($rtoi(q.z * 32700.0 / n));
			end
		end else if (mode < 8) begin
			q.w = 16'($signed(16'($urandom_range(511))) - 256);
			q.x = 16'($signed(16'($urandom_range(511))) - 256);
		end
		return q;
	endfunction

	// count cycles and stop a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t timeout", $time);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// drive downstream ready, with one long hold-off
	initial begin
		bit hold_done;
		hold_done = 1'b0;
		repeat (6) @(negedge clk);
		while (!stim_done || angles_due.size() != 0) begin
			@(negedge clk);
			if (hold_off && !hold_done) begin
				out_ready <= 1'b0;
				repeat (300) @(negedge clk);
				hold_done = 1'b1;
			end
			out_ready <= (cycles < 500) ? 1'b1 : ($urandom_range(99) >= 10);
		end
		out_ready <= 1'b1;
	end

	// check each result word against the oldest prediction
	always @(posedge clk) begin
		euler_t got, exp_w;
		if (arst_n && out_valid && out_ready) begin
			got = {roll_angle, pitch_angle, yaw_angle, pitch_clamped};
			if (angles_due.size() == 0) begin
				$display("%0t unexpected word %h", $time, got);
				errors++;
			end else begin
				exp_w = angles_due.pop_front();
				if (got.roll !== exp_w.roll) begin
					$display("%0t roll exp %0d got %0d", $time, exp_w.roll, got.roll);
					errors++;
				end
				if (got.pitch !== exp_w.pitch) begin
					$display("%0t pitch exp %0d got %0d", $time, exp_w.pitch, got.pitch);
					errors++;
				end
				if (got.yaw !== exp_w.yaw) begin
					$display("%0t yaw exp %0d got %0d", $time, exp_w.yaw, got.yaw);
					errors++;
				end
				if (got.clamped !== exp_w.clamped) begin
					$display("%0t clamp exp %0d got %0d", $time, exp_w.clamped,
						got.clamped);
					errors++;
				end
			end
		end
	end

	initial begin
		row_t rows[$];
		int waited;
		// identity, pure rotations, extremes and pitch saturation
		rows = '{
			'{'{16'sh7FFF, 16'sh0000, 16'sh0000, 16'sh0000}, 1'b1,
				'{16'sd0, 15'sd0, 16'sd0, 1'b0}},
			'{'{16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000}, 1'b1,
				'{16'sd0, 15'sd0, 16'sd0, 1'b0}},
			'{'{16'sh5A82, 16'sh0000, 16'sh5A82, 16'sh0000}, 1'b0, '0},
			'{'{16'sh5A82, 16'sh0000, -16'sh5A82, 16'sh0000}, 1'b0, '0},
			'{'{16'sh7FFF, 16'sh0000, 16'sh7FFF, 16'sh0000}, 1'b1,
				'{16'sd25736, 15'sd12868, 16'sd25736, 1'b1}},
			'{'{16'sh7FFF, 16'sh0000, -16'sh7FFF, 16'sh0000}, 1'b1,
				'{16'sd25736, -15'sd12868, 16'sd25736, 1'b1}},
			'{'{16'sh0000, 16'sh7FFF, 16'sh0000, 16'sh0000}, 1'b0, '0},
			'{'{16'sh0000, 16'sh0000, 16'sh0000, 16'sh7FFF}, 1'b0, '0},
			'{'{16'sh0000, 16'sh0000, 16'sh7FFF, 16'sh0000}, 1'b0, '0},
			'{'{16'sh5A82, 16'sh5A82, 16'sh0000, 16'sh0000}, 1'b0, '0},
			'{'{16'sh5A82, 16'sh0000, 16'sh0000, -16'sh5A82}, 1'b0, '0},
			'{'{-16'sh8000, -16'sh8000, -16'sh8000, -16'sh8000}, 1'b0, '0},
			'{'{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF}, 1'b0, '0},
			'{'{-16'sh8000, 16'sh7FFF, -16'sh8000, 16'sh7FFF}, 1'b0, '0},
			'{'{16'sh0001, -16'sh0001, 16'sh0001, -16'sh0001}, 1'b0, '0},
			'{'{16'sh4000, 16'sh4000, 16'sh4000, 16'sh4000}, 1'b0, '0},
			'{'{16'sh4000, -16'sh4000, 16'sh4000, -16'sh4000}, 1'b0, '0},
			'{'{16'sh1000, 16'sh7000, -16'sh2000, 16'sh3000}, 1'b0, '0}
		};
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		foreach (rows[i]) send_word(rows[i].q, rows[i].has_exp, rows[i].e);
		// random words; back-to-back at first, then with gaps and one long stall
		for (int i = 0; i < N_RANDOM; i++) begin
			if (i == 900) hold_off = 1'b1;
			send_word(rand_quat(), 1'b0, '0);
		end
		in_valid <= 1'b0;
		stim_done = 1'b1;
		waited = 0;
		while (angles_due.size() != 0 && waited < 20000) begin
			@(posedge clk);
			waited++;
		end
		repeat (LATENCY + 10) @(posedge clk);
		if (errors == 0 && angles_due.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

/* files.f */
hw/rtl/q2e_pkg.sv
hw/rtl/q2e_sqrt_cell.sv
hw/rtl/q2e_cordic_cell.sv
hw/rtl/quaternion_to_euler_core.sv
tb/tb_quaternion_to_euler_core.sv
